FILE: rtl/core/srw_pkg.sv
// srw_pkg: shared types and constants of the selective-repeat receive window.
// Reply kinds, sequencer states and the control/status bundles of the slide unit.
// No dependencies.
package srw_pkg;

    localparam int CFG_W   = 6;
    localparam int COUNT_W = 6;
    localparam int KIND_W  = 2;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_NACK    = 2'd1,
        KIND_IGNORED = 2'd2,
        KIND_DONE    = 2'd3
    } reply_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SLIDE,
        ST_DONE
    } srw_state_t;

    typedef struct packed {
        logic clear_cnt;
        logic set_mark;
        logic shift;
    } slide_ctrl_t;

    typedef struct packed {
        logic head_set;
        logic cnt_full;
    } slide_stat_t;

endpackage

FILE: rtl/core/selective_repeat_receiver_window_unit.sv
// selective_repeat_receiver_window_unit: receive side of a selective-repeat window.
// Sequencer around srw_classify and the bit-serial slide unit srw_slide.
// Depends on srw_pkg, srw_classify, srw_slide.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  header  | s_valid s_ready s_seq_num s_damaged       | in
//          | s_end_marker                              |
//  reply   | m_valid m_ready m_reply_kind m_reply_seq  | out
//          | m_release_count m_release_first m_new_base|
//  config  | cfg_valid cfg_ready cfg_window_size       | in
//
// A header goes from transfer to the evaluate state and, when not damaged, to the
// slide state, where the slide unit moves the base one slot a cycle while the head
// slot is marked. Damaged headers and headers from the end marker on skip it.
// s_ready is high only while the sequencer is idle; the reply sits in an output
// register, so the next header is taken while the reply waits for m_ready.
// Synchronous active-low reset: base 0, marks cleared, window size 4.
module selective_repeat_receiver_window_unit #(
    parameter int SEQ_BITS   = 16,
    parameter int WINDOW_MAX = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [SEQ_BITS-1:0]          s_seq_num,
    input  logic                         s_damaged,
    input  logic                         s_end_marker,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [srw_pkg::KIND_W-1:0]   m_reply_kind,
    output logic [SEQ_BITS-1:0]          m_reply_seq,
    output logic [srw_pkg::COUNT_W-1:0]  m_release_count,
    output logic [SEQ_BITS-1:0]          m_release_first,
    output logic [SEQ_BITS-1:0]          m_new_base,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [srw_pkg::CFG_W-1:0]    cfg_window_size
);
    import srw_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    srw_state_t state_reg, state_next;

    logic [CFG_W-1:0]    win_reg;
    logic                finished_reg, finished_next;
    logic [SEQ_BITS-1:0] seq_reg;
    logic                dmg_reg;
    logic                end_reg;
    reply_kind_t         kind_reg;
    logic [SEQ_BITS-1:0] rseq_reg;
    logic [SEQ_BITS-1:0] first_reg;

    logic                m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [SEQ_BITS-1:0] out_rseq_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [SEQ_BITS-1:0] out_first_reg;
    logic [SEQ_BITS-1:0] out_base_reg;

    reply_kind_t         cls_kind;
    logic [SEQ_BITS-1:0] cls_rseq;
    logic                cls_in_window;
    logic [IDX_W-1:0]    cls_idx;
    logic                cls_slide;

    slide_ctrl_t         sl_ctrl;
    slide_stat_t         sl_stat;
    logic [CNT_W-1:0]    sl_cnt;
    logic [SEQ_BITS-1:0] sl_base;

    logic s_xfer;
    logic load_out;
    logic eval_en;

    srw_classify #(
        .SEQ_BITS   (SEQ_BITS),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_classify (
        .seq        (seq_reg),
        .base       (sl_base),
        .win_cfg    (win_reg),
        .damaged    (dmg_reg),
        .end_marker (end_reg),
        .finished   (finished_reg),
        .kind       (cls_kind),
        .rseq       (cls_rseq),
        .in_window  (cls_in_window),
        .mark_idx   (cls_idx),
        .slide_en   (cls_slide)
    );

    srw_slide #(
        .SEQ_BITS   (SEQ_BITS),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_slide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sl_ctrl),
        .set_idx (cls_idx),
        .stat    (sl_stat),
        .cnt     (sl_cnt),
        .base    (sl_base)
    );

    assign cfg_ready = 1'b1;
    assign s_xfer    = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = cls_slide ? ST_SLIDE : ST_DONE;
            end
            ST_SLIDE: begin
                if (!sl_stat.head_set || sl_stat.cnt_full) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        eval_en  = 1'b0;
        load_out = 1'b0;
        sl_ctrl  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_EVAL: begin
                eval_en           = 1'b1;
                sl_ctrl.clear_cnt = 1'b1;
                sl_ctrl.set_mark  = cls_in_window;
            end
            ST_SLIDE: begin
                sl_ctrl.shift = sl_stat.head_set && !sl_stat.cnt_full;
            end
            ST_DONE: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        finished_next = finished_reg;
        if (eval_en && (cls_kind == KIND_DONE)) begin
            finished_next = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            win_reg      <= WINDOW_RESET;
            finished_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            finished_reg <= finished_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                win_reg <= cfg_window_size;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            seq_reg <= s_seq_num;
            dmg_reg <= s_damaged;
            end_reg <= s_end_marker;
        end
        if (eval_en) begin
            kind_reg  <= cls_kind;
            rseq_reg  <= cls_rseq;
            first_reg <= sl_base;
        end
        if (load_out) begin
            out_kind_reg  <= kind_reg;
            out_rseq_reg  <= rseq_reg;
            out_count_reg <= COUNT_W'(sl_cnt);
            out_first_reg <= first_reg;
            out_base_reg  <= sl_base;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_reply_kind    = out_kind_reg;
    assign m_reply_seq     = out_rseq_reg;
    assign m_release_count = out_count_reg;
    assign m_release_first = out_first_reg;
    assign m_new_base      = out_base_reg;

endmodule

FILE: rtl/core/srw_classify.sv
// srw_classify: sorts one packet header against the receive window.
// Clamps the window size, computes the distance ahead of and behind the base.
// Depends on srw_pkg.
module srw_classify #(
    parameter int SEQ_BITS   = 16,
    parameter int WINDOW_MAX = 32,
    localparam int IDX_W     = $clog2(WINDOW_MAX)
) (
    input  logic [SEQ_BITS-1:0]        seq,
    input  logic [SEQ_BITS-1:0]        base,
    input  logic [srw_pkg::CFG_W-1:0]  win_cfg,
    input  logic                       damaged,
    input  logic                       end_marker,
    input  logic                       finished,
    output srw_pkg::reply_kind_t       kind,
    output logic [SEQ_BITS-1:0]        rseq,
    output logic                       in_window,
    output logic [IDX_W-1:0]           mark_idx,
    output logic                       slide_en
);
    import srw_pkg::*;

    localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int MAX_AB = (SEQ_BITS > WIN_W) ? SEQ_BITS : WIN_W;
    localparam int MAX_W  = (MAX_AB > CFG_W) ? MAX_AB : CFG_W;
    localparam int CMP_W  = MAX_W + 1;

    logic [CMP_W-1:0]    cfg_ext;
    logic [CMP_W-1:0]    max_ext;
    logic [CMP_W-1:0]    eff_win;
    logic [SEQ_BITS-1:0] ahead;
    logic [SEQ_BITS-1:0] behind;
    logic [CMP_W-1:0]    ahead_ext;
    logic [CMP_W-1:0]    behind_ext;
    logic                closing;

    assign cfg_ext = CMP_W'(win_cfg);
    assign max_ext = CMP_W'(WINDOW_MAX);

    // zero acts as one, anything above the storage acts as the storage size
    always_comb begin
        if (cfg_ext == '0) begin
            eff_win = CMP_W'(1);
        end else if (cfg_ext > max_ext) begin
            eff_win = max_ext;
        end else begin
            eff_win = cfg_ext;
        end
    end

    assign ahead      = seq - base;
    assign behind     = base - seq;
    assign ahead_ext  = CMP_W'(ahead);
    assign behind_ext = CMP_W'(behind);
    assign mark_idx   = ahead_ext[IDX_W-1:0];
    assign closing    = finished || end_marker;

    always_comb begin
        kind      = KIND_IGNORED;
        rseq      = '0;
        in_window = 1'b0;
        slide_en  = 1'b0;
        if (closing) begin
            kind = KIND_DONE;
        end else if (damaged) begin
            kind = KIND_NACK;
        end else begin
            slide_en = 1'b1;
            if (ahead_ext < eff_win) begin
                kind      = KIND_ACK;
                rseq      = seq;
                in_window = 1'b1;
            end else if ((behind_ext != '0) && (behind_ext <= eff_win)) begin
                // duplicate just below the base, ack again
                kind = KIND_ACK;
                rseq = seq;
            end
        end
    end

endmodule

FILE: rtl/core/srw_slide.sv
// srw_slide: received-mark bitmap, window base and release counter.
// Slides the base one slot per cycle while the shift control is asserted.
// Depends on srw_pkg.
module srw_slide #(
    parameter int SEQ_BITS   = 16,
    parameter int WINDOW_MAX = 32,
    localparam int IDX_W     = $clog2(WINDOW_MAX),
    localparam int CNT_W     = $clog2(WINDOW_MAX + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  srw_pkg::slide_ctrl_t ctrl,
    input  logic [IDX_W-1:0]     set_idx,
    output srw_pkg::slide_stat_t stat,
    output logic [CNT_W-1:0]     cnt,
    output logic [SEQ_BITS-1:0]  base
);
    import srw_pkg::*;

    logic [WINDOW_MAX-1:0] marks_reg, marks_next;
    logic [SEQ_BITS-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    always_comb begin
        marks_next = marks_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        if (ctrl.clear_cnt) begin
            cnt_next = '0;
        end
        if (ctrl.set_mark) begin
            marks_next[set_idx] = 1'b1;
        end
        if (ctrl.shift) begin
            marks_next = {1'b0, marks_reg[WINDOW_MAX-1:1]};
            base_next  = base_reg + SEQ_BITS'(1);
            cnt_next   = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg <= '0;
            base_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            marks_reg <= marks_next;
            base_reg  <= base_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign stat.head_set = marks_reg[0];
    assign stat.cnt_full = (cnt_reg == CNT_W'(WINDOW_MAX));
    assign cnt           = cnt_reg;
    assign base          = base_reg;

endmodule
